[rtl/mrbm_pkg.sv]
// shared constants, sequencer states and stack control types for the
// maximal rectangle unit; no dependencies
package mrbm_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = $clog2(MAX_COLS + 1);
  localparam int H_W      = $clog2(MAX_ROWS + 1);
  localparam int AREA_W   = 17;
  localparam int PROD_W   = H_W + CNT_W;

  localparam logic [AREA_W-1:0] AREA_MAX    = {AREA_W{1'b1}};
  localparam logic [CNT_W-1:0]  NCOLS_RESET = CNT_W'(4);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHECK,
    S_POP_RD,
    S_POP_MUL,
    S_POP_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic pop_rd;
    logic pop_adv;
  } stk_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [H_W-1:0]   top_h;
    logic [COL_W-1:0] below_idx;
  } stk_stat_t;

endpackage

[rtl/mrbm_stack.sv]
// monotonic column stack: top entry in registers, lower entries in a memory
// depends on mrbm_pkg
module mrbm_stack (
  input  logic                     clk,
  input  logic                     rst,
  input  mrbm_pkg::stk_cmd_t       cmd,
  input  logic [mrbm_pkg::COL_W-1:0] push_idx,
  input  logic [mrbm_pkg::H_W-1:0]   push_h,
  output mrbm_pkg::stk_stat_t      stat
);
  import mrbm_pkg::*;

  logic [COL_W+H_W-1:0] mem [MAX_COLS];
  logic [COL_W+H_W-1:0] rd;
  logic [CNT_W-1:0]     depth;
  logic [COL_W-1:0]     top_idx;
  logic [H_W-1:0]       top_h;
  logic [CNT_W-1:0]     wr_addr;
  logic [CNT_W-1:0]     rd_addr;

  assign wr_addr = depth - CNT_W'(1);
  assign rd_addr = depth - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (cmd.push && depth != '0) begin
      mem[wr_addr[COL_W-1:0]] <= {top_idx, top_h};
    end
    if (cmd.pop_rd) begin
      rd <= mem[rd_addr[COL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_idx <= push_idx;
      top_h   <= push_h;
    end else if (cmd.pop_adv && depth != '0) begin
      top_idx <= rd[COL_W+H_W-1:H_W];
      top_h   <= rd[H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push) begin
      depth <= depth + CNT_W'(1);
    end else if (cmd.pop_rd && depth != '0) begin
      depth <= depth - CNT_W'(1);
    end
  end

  assign stat.depth     = depth;
  assign stat.top_h     = top_h;
  assign stat.below_idx = rd[COL_W+H_W-1:H_W];

endmodule

[rtl/max_rectangle_binary_matrix_unit.sv]
// maximal all-ones rectangle over a streamed binary matrix
// a cell is taken while busy is low, then passes S_UPD and S_CHECK; each stack pop it
// causes adds S_POP_RD, S_POP_MUL and S_POP_CMP, a row-end cell pops every entry left,
// and the end-of-matrix cell ends in S_DONE, in which done and max_area are shown
// cells go one at a time through the single pop/score unit; results cannot be held off
// synchronous active-high rst clears heights, stack, best area and sets num_cols to 4
module max_rectangle_binary_matrix_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cell_bit,
  input  logic                         end_of_matrix,
  output logic                         done,
  output logic [mrbm_pkg::AREA_W-1:0]  max_area,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mrbm_pkg::CNT_W-1:0]   cfg_data
);
  import mrbm_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  num_cols;
  logic [CNT_W-1:0]  ncols;
  logic [COL_W-1:0]  col_position;
  logic [COL_W-1:0]  pos;
  logic              cell_q;
  logic              last_q;
  logic              row_end;
  logic              flush;
  logic [H_W-1:0]    hmem [MAX_COLS];
  logic [MAX_COLS-1:0] hvalid;
  logic [H_W-1:0]    h_rd;
  logic [H_W-1:0]    h_old;
  logic [H_W-1:0]    new_h;
  logic [H_W-1:0]    cur_h;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  right;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  width;
  logic [PROD_W-1:0] prod;
  logic [AREA_W-1:0] area_sat;
  logic [AREA_W-1:0] best;
  logic              pop_now;
  stk_cmd_t          cmd;
  stk_stat_t         stat;

  mrbm_stack u_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .push_idx (pos),
    .push_h   (cur_h),
    .stat     (stat)
  );

  assign cfg_ready = !busy;

  always_comb begin
    if (num_cols == '0) begin
      ncols = CNT_W'(1);
    end else if (num_cols > CNT_W'(MAX_COLS)) begin
      ncols = CNT_W'(MAX_COLS);
    end else begin
      ncols = num_cols;
    end
  end

  // height update of the current column
  assign pos_inc = {1'b0, pos} + CNT_W'(1);
  assign h_old   = hvalid[pos] ? h_rd : '0;
  always_comb begin
    if (!cell_q) begin
      new_h = '0;
    end else if (h_old < H_W'(MAX_ROWS)) begin
      new_h = h_old + H_W'(1);
    end else begin
      new_h = h_old;
    end
  end

  // rectangle width and saturated area
  assign right    = flush ? pos_inc : {1'b0, pos};
  assign left     = (stat.depth != '0) ? {1'b0, stat.below_idx} + CNT_W'(1) : '0;
  assign width    = (right > left) ? right - left : '0;
  assign area_sat = (prod > PROD_W'(AREA_MAX)) ? AREA_MAX : prod[AREA_W-1:0];
  assign pop_now  = (stat.depth != '0) && (stat.top_h >= cur_h);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (pop_now || row_end) begin
          state_next = S_POP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP_RD: begin
        state_next = S_POP_MUL;
      end
      S_POP_MUL: begin
        state_next = S_POP_CMP;
      end
      S_POP_CMP: begin
        if (!flush) begin
          state_next = S_CHECK;
        end else if (stat.depth != '0) begin
          state_next = S_POP_RD;
        end else if (last_q) begin
          state_next = S_DONE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_CHECK: begin
        cmd.push = !pop_now;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
      end
      S_POP_MUL: begin
        cmd.pop_adv = 1'b1;
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign max_area = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NCOLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_cols <= cfg_data;
    end
  end

  // column height memory
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      h_rd <= hmem[col_position];
    end
    if (state == S_UPD) begin
      hmem[pos] <= new_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid       <= '0;
      col_position <= '0;
      best         <= '0;
      row_end      <= 1'b0;
      flush        <= 1'b0;
    end else begin
      case (state)
        S_UPD: begin
          hvalid[pos] <= 1'b1;
          row_end     <= last_q || (pos_inc >= ncols);
          flush       <= 1'b0;
        end
        S_CHECK: begin
          if (!pop_now) begin
            flush <= row_end;
            if (!row_end) col_position <= pos_inc[COL_W-1:0];
          end
        end
        S_POP_CMP: begin
          if (area_sat > best) best <= area_sat;
          if (flush && stat.depth == '0) col_position <= '0;
        end
        S_DONE: begin
          hvalid       <= '0;
          best         <= '0;
          col_position <= '0;
        end
        default: begin
          hvalid <= hvalid;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cell_q <= cell_bit;
      last_q <= end_of_matrix;
      pos    <= col_position;
    end
    if (state == S_UPD) begin
      cur_h <= new_h;
    end
    if (state == S_POP_MUL) begin
      prod <= PROD_W'(stat.top_h) * PROD_W'(width);
    end
  end

endmodule

[rtl/mrbm_checker.sv]
// port-level checks for the maximal rectangle unit, bound to the top level
// depends on mrbm_pkg and max_rectangle_binary_matrix_unit
module mrbm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        end_of_matrix,
  input logic                        done,
  input logic [mrbm_pkg::AREA_W-1:0] max_area
);
  import mrbm_pkg::*;

  logic last_pending;

  // an end-of-matrix transfer is outstanding until its result is shown
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pending <= 1'b0;
    end else if (start && !busy) begin
      last_pending <= end_of_matrix;
    end else if (done) begin
      last_pending <= 1'b0;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_cause: assert property (@(posedge clk) disable iff (rst) done |-> last_pending)
    else $error("result without an end-of-matrix transfer");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer taken but unit not busy");

  a_area_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (max_area <= AREA_W'(MAX_COLS * MAX_ROWS)))
    else $error("area beyond matrix size");

endmodule

bind max_rectangle_binary_matrix_unit mrbm_checker u_mrbm_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .end_of_matrix (end_of_matrix),
  .done          (done),
  .max_area      (max_area)
);
